[design/efr_pkg.sv]
// Shared types, constants and helpers for the edge-function triangle rasterizer.
`default_nettype none

package efr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 24;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int EDGE_BITS   = PROD_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [EDGE_BITS-1:0]  t_edge;
    typedef logic [COLOR_BITS-1:0]        t_color;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EVAL = 1'b1
    } t_back_state;

    typedef struct packed {
        logic   operation;
        t_coord vertex_a_x;
        t_coord vertex_a_y;
        t_coord vertex_b_x;
        t_coord vertex_b_y;
        t_coord vertex_c_x;
        t_coord vertex_c_y;
        t_color fill_color;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   covered;
        t_color pixel_color;
        logic   last_pixel;
    } t_out_item;

    // Classified item as it sits in the queue
    typedef struct packed {
        t_op    op;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
        t_color color;
        t_coord min_x;
        t_coord min_y;
        t_coord max_x;
        t_coord max_y;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Difference of two coordinates, one bit wider so it cannot overflow
    function automatic t_diff sdiff(input t_coord a, input t_coord b);
        t_diff d;
        d = t_diff'(a) - t_diff'(b);
        return d;
    endfunction

    function automatic t_coord min3(input t_coord a, input t_coord b, input t_coord c);
        t_coord m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_coord max3(input t_coord a, input t_coord b, input t_coord c);
        t_coord m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

`default_nettype wire

[design/edge_function_triangle_raster.sv]
// Top level of the edge-function triangle rasterizer.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): a load item latches
// three signed vertices and a fill color and places the scan on the top-left
// corner of their bounding box; a step item reports the next pixel of the box
// in row-major order. Loads and steps taken while no triangle is active give
// no result; a load during a scan abandons the old one.
// Output channel (o_out_valid / i_out_stall / o_out_item): an item for each step
// taken while a triangle is active, with pixel coordinates, coverage (every edge
// function >= 0), color and a flag on the final box pixel.
// Items pass through a two-entry queue to the scan engine. For a step the engine
// first registers the edge products, then compares the edges into the output
// register, and takes no new item from the queue until that is done; a load is
// taken in the idle state alone.
// While the receiver stalls, the finished pixel holds in the output register,
// the queue fills and then o_in_stall rises. Synchronous reset clears the
// queue, drops any active triangle and empties the output register.
`default_nettype none

module edge_function_triangle_raster (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire efr_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output efr_pkg::t_out_item       o_out_item
);
    import efr_pkg::*;

    t_entry        s_push_entry;
    t_entry        s_head;
    t_queue_status s_q_status;
    logic          s_push;
    logic          s_pop;

    efr_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (s_q_status),
        .o_push     (s_push),
        .o_entry    (s_push_entry)
    );

    efr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_push),
        .i_entry  (s_push_entry),
        .i_pop    (s_pop),
        .o_head   (s_head),
        .o_status (s_q_status)
    );

    efr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (s_head),
        .i_q_status  (s_q_status),
        .o_pop       (s_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[design/efr_queue.sv]
// Short FIFO of classified items between the front and the back.
`default_nettype none

module efr_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire efr_pkg::t_entry        i_entry,
    input  wire logic                   i_pop,
    output efr_pkg::t_entry             o_head,
    output efr_pkg::t_queue_status      o_status
);
    import efr_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_BITS:0]    r_count, n_count;

    // Report fill state and head entry
    always_comb begin
        o_status.full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        o_head         = r_mem[r_rd_ptr];
    end

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_BITS'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (QPTR_BITS+1)'(1);
            2'b01:   n_count = r_count - (QPTR_BITS+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[design/efr_front.sv]
// Front end: accepts items, classifies them and prepares the bounding box.
`default_nettype none

module efr_front (
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire efr_pkg::t_in_item      i_in_item,
    input  wire efr_pkg::t_queue_status i_q_status,
    output logic                        o_push,
    output efr_pkg::t_entry             o_entry
);
    import efr_pkg::*;

    // Hold off the sender while the queue is full
    always_comb begin
        o_in_stall = i_q_status.full;
        o_push     = i_in_valid && !i_q_status.full;
    end

    // Classify the item and work out the box of the vertices
    always_comb begin
        o_entry.op    = t_op'(i_in_item.operation);
        o_entry.ax    = i_in_item.vertex_a_x;
        o_entry.ay    = i_in_item.vertex_a_y;
        o_entry.bx    = i_in_item.vertex_b_x;
        o_entry.by    = i_in_item.vertex_b_y;
        o_entry.cx    = i_in_item.vertex_c_x;
        o_entry.cy    = i_in_item.vertex_c_y;
        o_entry.color = i_in_item.fill_color;
        o_entry.min_x = min3(i_in_item.vertex_a_x, i_in_item.vertex_b_x, i_in_item.vertex_c_x);
        o_entry.min_y = min3(i_in_item.vertex_a_y, i_in_item.vertex_b_y, i_in_item.vertex_c_y);
        o_entry.max_x = max3(i_in_item.vertex_a_x, i_in_item.vertex_b_x, i_in_item.vertex_c_x);
        o_entry.max_y = max3(i_in_item.vertex_a_y, i_in_item.vertex_b_y, i_in_item.vertex_c_y);
    end

endmodule

`default_nettype wire

[design/efr_back.sv]
// Back end: holds the triangle, walks the box and evaluates the edge functions.
`default_nettype none

module efr_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire efr_pkg::t_entry        i_head,
    input  wire efr_pkg::t_queue_status i_q_status,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output efr_pkg::t_out_item          o_out_item
);
    import efr_pkg::*;

    t_back_state r_state, n_state;

    // Triangle state
    t_coord r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    t_coord r_min_x, r_max_x, r_max_y;
    t_coord r_scan_x, r_scan_y;
    t_color r_color;
    logic   r_busy;

    // Evaluation stage: products and pixel details
    t_prod  r_lhs0, r_rhs0, r_lhs1, r_rhs1, r_lhs2, r_rhs2;
    t_coord r_eval_x, r_eval_y;
    logic   r_eval_last;
    t_color r_eval_color;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    logic   s_take, s_is_load, s_is_step, s_last, s_load_out;
    t_edge  s_w0, s_w1, s_w2;
    t_prod  s_lhs0, s_rhs0, s_lhs1, s_rhs1, s_lhs2, s_rhs2;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Next state and handshake with queue and output register
    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        s_load_out  = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (i_head.op == OP_STEP && r_busy) begin
                        n_state = BK_EVAL;
                    end
                end
            end
            BK_EVAL: begin
                if (!r_out_valid || !i_out_stall) begin
                    s_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
        s_take    = o_pop;
        s_is_load = s_take && (i_head.op == OP_LOAD);
        s_is_step = s_take && (i_head.op == OP_STEP) && r_busy;
        s_last    = (r_scan_x == r_max_x) && (r_scan_y == r_max_y);
    end

    // Edge products for the current scan position
    always_comb begin
        s_lhs0 = sdiff(r_scan_y, r_by) * sdiff(r_cx, r_bx);
        s_rhs0 = sdiff(r_scan_x, r_bx) * sdiff(r_cy, r_by);
        s_lhs1 = sdiff(r_scan_y, r_cy) * sdiff(r_ax, r_cx);
        s_rhs1 = sdiff(r_scan_x, r_cx) * sdiff(r_ay, r_cy);
        s_lhs2 = sdiff(r_scan_y, r_ay) * sdiff(r_bx, r_ax);
        s_rhs2 = sdiff(r_scan_x, r_ax) * sdiff(r_by, r_ay);
    end

    // Edge values from the registered products
    always_comb begin
        s_w0 = t_edge'(r_lhs0) - t_edge'(r_rhs0);
        s_w1 = t_edge'(r_lhs1) - t_edge'(r_rhs1);
        s_w2 = t_edge'(r_lhs2) - t_edge'(r_rhs2);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (s_is_load) begin
                r_busy <= 1'b1;
            end else if (s_is_step && s_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Latch a new triangle or advance the scan
    always_ff @(posedge i_clk) begin
        if (s_is_load) begin
            r_ax     <= i_head.ax;
            r_ay     <= i_head.ay;
            r_bx     <= i_head.bx;
            r_by     <= i_head.by;
            r_cx     <= i_head.cx;
            r_cy     <= i_head.cy;
            r_color  <= i_head.color;
            r_min_x  <= i_head.min_x;
            r_max_x  <= i_head.max_x;
            r_max_y  <= i_head.max_y;
            r_scan_x <= i_head.min_x;
            r_scan_y <= i_head.min_y;
        end else if (s_is_step && !s_last) begin
            if (r_scan_x == r_max_x) begin
                r_scan_x <= r_min_x;
                r_scan_y <= r_scan_y + t_coord'(1);
            end else begin
                r_scan_x <= r_scan_x + t_coord'(1);
            end
        end
    end

    // Capture products and pixel details for the evaluation stage
    always_ff @(posedge i_clk) begin
        if (s_is_step) begin
            r_lhs0       <= s_lhs0;
            r_rhs0       <= s_rhs0;
            r_lhs1       <= s_lhs1;
            r_rhs1       <= s_rhs1;
            r_lhs2       <= s_lhs2;
            r_rhs2       <= s_rhs2;
            r_eval_x     <= r_scan_x;
            r_eval_y     <= r_scan_y;
            r_eval_last  <= s_last;
            r_eval_color <= r_color;
        end
    end

    // Load the output register with the finished pixel
    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_out_item.pixel_x     <= r_eval_x;
            r_out_item.pixel_y     <= r_eval_y;
            r_out_item.covered     <= !s_w0[EDGE_BITS-1] && !s_w1[EDGE_BITS-1]
                                      && !s_w2[EDGE_BITS-1];
            r_out_item.pixel_color <= r_eval_color;
            r_out_item.last_pixel  <= r_eval_last;
        end
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Testbench for the edge-function triangle rasterizer: directed and random scans checked per pixel.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import efr_pkg::*;

    // Limit on the whole run in cycles; keep a wide margin
    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 100;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int useful_items   = 0;

    t_out_item expected_pixels[$];

    // Rasterizer state as seen by the predictor
    t_coord va_x = '0, va_y = '0, vb_x = '0, vb_y = '0, vc_x = '0, vc_y = '0;
    t_coord box_lo_x = '0, box_lo_y = '0, box_hi_x = '0, box_hi_y = '0;
    t_coord scan_px = '0, scan_py = '0;
    bit     scan_active = 1'b0;
    t_color tri_color = '0;

    edge_function_triangle_raster dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    // Draw the receiver stall for the next cycle
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Edge function evaluated exactly in 64 bits
    function automatic longint edge_value(input t_coord x0, input t_coord y0,
                                          input t_coord x1, input t_coord y1,
                                          input t_coord px, input t_coord py);
        return (longint'(py) - longint'(y0)) * (longint'(x1) - longint'(x0))
             - (longint'(px) - longint'(x0)) * (longint'(y1) - longint'(y0));
    endfunction

    // Advance the predicted rasterizer by one accepted item
    task automatic rasterize_item(input t_in_item it);
        t_out_item px;
        longint    e0, e1, e2;
        if (it.operation == OP_LOAD) begin
            va_x = it.vertex_a_x;
            va_y = it.vertex_a_y;
            vb_x = it.vertex_b_x;
            vb_y = it.vertex_b_y;
            vc_x = it.vertex_c_x;
            vc_y = it.vertex_c_y;
            tri_color = it.fill_color;
            box_lo_x = va_x;
            box_hi_x = va_x;
            box_lo_y = va_y;
            box_hi_y = va_y;
            if (vb_x < box_lo_x) box_lo_x = vb_x;
            if (vc_x < box_lo_x) box_lo_x = vc_x;
            if (vb_x > box_hi_x) box_hi_x = vb_x;
            if (vc_x > box_hi_x) box_hi_x = vc_x;
            if (vb_y < box_lo_y) box_lo_y = vb_y;
            if (vc_y < box_lo_y) box_lo_y = vc_y;
            if (vb_y > box_hi_y) box_hi_y = vb_y;
            if (vc_y > box_hi_y) box_hi_y = vc_y;
            scan_px = box_lo_x;
            scan_py = box_lo_y;
            scan_active = 1'b1;
            useful_items++;
        end else if (scan_active) begin
            e0 = edge_value(vb_x, vb_y, vc_x, vc_y, scan_px, scan_py);
            e1 = edge_value(vc_x, vc_y, va_x, va_y, scan_px, scan_py);
            e2 = edge_value(va_x, va_y, vb_x, vb_y, scan_px, scan_py);
            px.pixel_x     = scan_px;
            px.pixel_y     = scan_py;
            px.covered     = (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
            px.pixel_color = tri_color;
            px.last_pixel  = (scan_px == box_hi_x) && (scan_py == box_hi_y);
            expected_pixels.push_back(px);
            useful_items++;
            // Move the scan in row-major order, stop after the last pixel
            if (px.last_pixel) begin
                scan_active = 1'b0;
            end else if (scan_px == box_hi_x) begin
                scan_px = box_lo_x;
                scan_py = scan_py + 1'b1;
            end else begin
                scan_px = scan_px + 1'b1;
            end
        end
    endtask

    // Offer one item after a random gap, hold it until accepted, then predict
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        rasterize_item(it);
    endtask

    function automatic t_in_item load_item(input t_coord ax, input t_coord ay,
                                           input t_coord bx, input t_coord by,
                                           input t_coord cx, input t_coord cy,
                                           input t_color color);
        t_in_item it;
        it.operation  = OP_LOAD;
        it.vertex_a_x = ax;
        it.vertex_a_y = ay;
        it.vertex_b_x = bx;
        it.vertex_b_y = by;
        it.vertex_c_x = cx;
        it.vertex_c_y = cy;
        it.fill_color = color;
        return it;
    endfunction

    // Step with random content in the unused fields
    function automatic t_in_item step_item();
        t_in_item it;
        it = t_in_item'({$urandom(), $urandom(), $urandom()});
        it.operation = OP_STEP;
        return it;
    endfunction

    task automatic send_steps(input int n);
        repeat (n) send_item(step_item());
    endtask

    // Random coordinate in the box that runs from base to base plus span
    function automatic t_coord coord_in_box(input int base, input int span);
        return t_coord'(base + int'($urandom_range(span)));
    endfunction

    // Compare one field and log a difference
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Check each accepted pixel against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: pixel item with nothing expected, actual %p", $time, out_item);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", want.pixel_x, out_item.pixel_x);
                check_field("pixel_y", want.pixel_y, out_item.pixel_y);
                check_field("covered", want.covered, out_item.covered);
                check_field("pixel_color", want.pixel_color, out_item.pixel_color);
                check_field("last_pixel", want.last_pixel, out_item.last_pixel);
            end
        end
    end

    // Steps with no triangle loaded must give nothing
    task automatic test_idle_steps();
        send_steps(3);
    endtask

    // Same box in both windings; only one fills
    task automatic test_winding();
        send_item(load_item(12'sd0, 12'sd0, 12'sd1, 12'sd0, 12'sd0, 12'sd1, 24'h123456));
        send_steps(4);
        send_item(load_item(12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 12'sd0, 24'hABCDEF));
        send_steps(4);
    endtask

    // Single point and collinear vertices; a step past the end is ignored
    task automatic test_degenerate();
        send_item(load_item(12'sd5, -12'sd3, 12'sd5, -12'sd3, 12'sd5, -12'sd3, 24'h00FF00));
        send_steps(2);
        send_item(load_item(-12'sd1, 12'sd7, 12'sd1, 12'sd7, 12'sd0, 12'sd7, 24'h0000FF));
        send_steps(3);
    endtask

    // Full-range triangle abandoned by a load, then the two corner points
    task automatic test_extremes();
        send_item(load_item(-12'sd2048, -12'sd2048, 12'sd2047, -12'sd2048,
                            -12'sd2048, 12'sd2047, 24'hFFFFFF));
        send_steps(2);
        send_item(load_item(12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047,
                            12'sd2047, 12'sd2047, 24'h000000));
        send_steps(1);
        send_item(load_item(-12'sd2048, -12'sd2048, -12'sd2048, -12'sd2048,
                            -12'sd2048, -12'sd2048, 24'hFFFFFF));
        send_steps(1);
    endtask

    // Random small triangles scanned fully, partly or past the end, plus wide noise loads
    task automatic test_random_scan(input int n_items);
        int goal, roll, span_x, span_y, base_x, base_y, pixels, steps;
        t_coord ax, ay, bx, by, cx, cy;
        goal = useful_items + n_items;
        while (useful_items < goal) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_item(load_item(t_coord'($urandom()), t_coord'($urandom()),
                                    t_coord'($urandom()), t_coord'($urandom()),
                                    t_coord'($urandom()), t_coord'($urandom()),
                                    t_color'($urandom())));
                send_steps($urandom_range(1, 5));
            end else begin
                span_x = ($urandom_range(9) == 0) ? $urandom_range(8, 15) : $urandom_range(4);
                span_y = ($urandom_range(9) == 0) ? $urandom_range(8, 15) : $urandom_range(4);
                base_x = int'($urandom_range(4095 - span_x)) - 2048;
                base_y = int'($urandom_range(4095 - span_y)) - 2048;
                ax = coord_in_box(base_x, span_x);
                bx = coord_in_box(base_x, span_x);
                cx = coord_in_box(base_x, span_x);
                ay = coord_in_box(base_y, span_y);
                by = coord_in_box(base_y, span_y);
                cy = coord_in_box(base_y, span_y);
                send_item(load_item(ax, ay, bx, by, cx, cy, t_color'($urandom())));
                pixels = (int'(box_hi_x) - int'(box_lo_x) + 1)
                       * (int'(box_hi_y) - int'(box_lo_y) + 1);
                if (roll < 25)
                    steps = $urandom_range(pixels - 1);
                else if (roll >= 90)
                    steps = pixels + $urandom_range(1, 3);
                else
                    steps = pixels;
                send_steps(steps);
            end
        end
    endtask

    initial begin
        // Hold reset, then release it at a clock edge
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_steps();
        test_winding();
        test_degenerate();
        test_extremes();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_scan(PHASE_ITEMS);
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        test_random_scan(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        test_random_scan(PHASE_ITEMS);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        test_random_scan(PHASE_ITEMS);

        // Drop valid and drain outstanding pixels
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/efr_pkg.sv
design/efr_queue.sv
design/efr_front.sv
design/efr_back.sv
design/edge_function_triangle_raster.sv
bench/testbench.sv
